[sv/fraction_add_multiply_reduce_defines.svh]
// assertion macros for the fraction add multiply reduce block
`ifndef FRACTION_ADD_MULTIPLY_REDUCE_DEFINES_SVH
`define FRACTION_ADD_MULTIPLY_REDUCE_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define FRAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked at every rising clock edge outside reset
`define FRAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/fram_pkg.sv]
// shared types and constants for the fraction add multiply reduce block
package fram_pkg;

   localparam int PART_WIDTH = 16;
   localparam int DEN_IN_W   = PART_WIDTH - 1;
   localparam int NUM_W      = 2 * PART_WIDTH;
   localparam int MAG_W      = 2 * PART_WIDTH - 1;
   localparam int DEN_W      = 2 * PART_WIDTH - 2;
   localparam int CNT_W      = $clog2(MAG_W);

   localparam logic [1:0] OP_REDUCE = 2'd0;
   localparam logic [1:0] OP_MUL    = 2'd1;
   localparam logic [1:0] OP_ADD    = 2'd2;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [PART_WIDTH-1:0] num_a;
      logic [DEN_IN_W-1:0]          den_a;
      logic signed [PART_WIDTH-1:0] num_b;
      logic [DEN_IN_W-1:0]          den_b;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
   } rsp_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] p0;
      logic signed [NUM_W-1:0] p1;
      logic [DEN_W-1:0]        pd;
   } mul_out_type;

   typedef struct packed {
      logic [MAG_W:0] diff;
      logic           borrow;
   } alu_out_type;

endpackage

[sv/fram_alu.sv]
// shared subtractor used by the gcd loop and the restoring divider
module fram_alu
   import fram_pkg::*;
(
   input  logic [MAG_W:0] alu_x,
   input  logic [MAG_W:0] alu_y,
   output alu_out_type    alu_out
);

   logic [MAG_W+1:0] full_diff;

   assign full_diff      = {1'b0, alu_x} - {1'b0, alu_y};
   assign alu_out.diff   = full_diff[MAG_W:0];
   assign alu_out.borrow = full_diff[MAG_W+1];

endmodule

[sv/fram_mul.sv]
// registered cross products of the two input fractions
module fram_mul
   import fram_pkg::*;
(
   input  logic        clock,
   input  logic        mul_en,
   input  req_type     mul_req,
   output mul_out_type mul_out
);

   logic signed [PART_WIDTH-1:0]   na;
   logic signed [PART_WIDTH-1:0]   nb;
   logic signed [PART_WIDTH:0]     mul_b;
   logic signed [PART_WIDTH-1:0]   da_s;
   logic signed [2*PART_WIDTH:0]   p0_full;
   logic signed [2*PART_WIDTH-1:0] p1_full;
   logic [DEN_W-1:0]               pd_full;
   mul_out_type                    mul_ff;
   mul_out_type                    mul_in;

   assign na    = mul_req.num_a;
   assign nb    = mul_req.num_b;
   assign da_s  = signed'({1'b0, mul_req.den_a});
   assign mul_b = (mul_req.opcode == OP_MUL) ? signed'({nb[PART_WIDTH-1], nb})
                                            : signed'({2'b00, mul_req.den_b});

   assign p0_full = na * mul_b;
   assign p1_full = nb * da_s;
   assign pd_full = mul_req.den_a * mul_req.den_b;

   always_comb begin
      mul_in    = mul_ff;
      if (mul_en) begin
         mul_in.p0 = p0_full[NUM_W-1:0];
         mul_in.p1 = p1_full[NUM_W-1:0];
         mul_in.pd = pd_full;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
   end

   assign mul_out = mul_ff;

endmodule

[sv/fraction_add_multiply_reduce.sv]
// top level: fraction reduce, multiply or add, then reduction to lowest terms
// steps: multiply, sum, then the binary gcd loop and the divisions of numerator and denominator;
// a zero denominator returns from the sum state with a zero result instead
// a new item is taken only when idle again, busy drops with the result strobe
// the gcd loop and both divisions share one 32-bit subtractor
// synchronous active-high reset returns to idle with no strobe pending
module fraction_add_multiply_reduce
   import fram_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

`include "fraction_add_multiply_reduce_defines.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_GCD  = 3'd3;
   localparam logic [2:0] ST_DIVN = 3'd4;
   localparam logic [2:0] ST_DIVD = 3'd5;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [MAG_W-1:0] a_ff, a_in;
   logic [MAG_W-1:0] b_ff, b_in;
   logic [MAG_W-1:0] m_ff, m_in;
   logic [MAG_W-1:0] d_ff, d_in;
   logic [MAG_W-1:0] g_ff, g_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   mul_out_type      mul_out;
   alu_out_type      alu_out;
   logic [MAG_W:0]   alu_x;
   logic [MAG_W:0]   alu_y;
   logic [MAG_W:0]   neg_diff;

   logic signed [NUM_W-1:0] raw_num;
   logic [DEN_W-1:0]        raw_den;
   logic [NUM_W-1:0]        abs_num;
   logic [MAG_W-1:0]        q_shift;
   logic [MAG_W-1:0]        rem_next;
   logic [NUM_W-1:0]        num_mag;

   fram_mul u_mul (
      .clock   (clock),
      .mul_en  (state_ff == ST_MUL),
      .mul_req (req_ff),
      .mul_out (mul_out)
   );

   fram_alu u_alu (
      .alu_x   (alu_x),
      .alu_y   (alu_y),
      .alu_out (alu_out)
   );

   assign alu_x = (state_ff == ST_GCD) ? {1'b0, a_ff} : {rem_ff, q_ff[MAG_W-1]};
   assign alu_y = (state_ff == ST_GCD) ? {1'b0, b_ff} : {1'b0, g_ff};

   assign neg_diff = ~alu_out.diff + 1'b1;
   assign q_shift  = {q_ff[MAG_W-2:0], ~alu_out.borrow};
   assign rem_next = alu_out.borrow ? {rem_ff[MAG_W-2:0], q_ff[MAG_W-1]}
                                    : alu_out.diff[MAG_W-1:0];
   assign num_mag  = {1'b0, m_ff};

   always_comb begin
      unique case (req_ff.opcode)
         OP_MUL: begin
            raw_num = mul_out.p0;
            raw_den = mul_out.pd;
         end
         OP_ADD: begin
            raw_num = mul_out.p0 + mul_out.p1;
            raw_den = mul_out.pd;
         end
         default: begin
            raw_num = {{(NUM_W-PART_WIDTH){req_ff.num_a[PART_WIDTH-1]}}, req_ff.num_a};
            raw_den = {{(DEN_W-DEN_IN_W){1'b0}}, req_ff.den_a};
         end
      endcase
   end

   assign abs_num = raw_num[NUM_W-1] ? (~raw_num + 1'b1) : raw_num;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (raw_den == '0) begin
               rsp_in.res_num = '0;
               rsp_in.res_den = '0;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               neg_in   = raw_num[NUM_W-1];
               a_in     = abs_num[MAG_W-1:0];
               m_in     = abs_num[MAG_W-1:0];
               b_in     = {1'b0, raw_den};
               d_in     = {1'b0, raw_den};
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               g_in     = a_ff | b_ff;
               rem_in   = '0;
               q_in     = m_ff;
               cnt_in   = CNT_W'(MAG_W - 1);
               state_in = ST_DIVN;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = {1'b0, a_ff[MAG_W-1:1]};
               b_in = {1'b0, b_ff[MAG_W-1:1]};
               m_in = {1'b0, m_ff[MAG_W-1:1]};
               d_in = {1'b0, d_ff[MAG_W-1:1]};
            end else if (!a_ff[0]) begin
               a_in = {1'b0, a_ff[MAG_W-1:1]};
            end else if (!b_ff[0]) begin
               b_in = {1'b0, b_ff[MAG_W-1:1]};
            end else if (!alu_out.borrow) begin
               a_in = alu_out.diff[MAG_W:1];
            end else begin
               b_in = neg_diff[MAG_W:1];
            end
         end
         ST_DIVN: begin
            rem_in = rem_next;
            q_in   = q_shift;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               m_in     = q_shift;
               rem_in   = '0;
               q_in     = d_ff;
               cnt_in   = CNT_W'(MAG_W - 1);
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            rem_in = rem_next;
            q_in   = q_shift;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rsp_in.res_num = neg_ff ? signed'(~num_mag + 1'b1) : signed'(num_mag);
               rsp_in.res_den = q_shift[DEN_W-1:0];
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FRAM_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy)
   `FRAM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FRAM_ASSERT_NOW(a_error_marker, clock, reset, rsp_valid && rsp_data.res_den == '0, rsp_data.res_num == '0)
   `FRAM_ASSERT_NOW(a_gcd_nonzero, clock, reset, state_ff == ST_DIVN || state_ff == ST_DIVD, g_ff != '0)

endmodule

[tb/fraction_add_multiply_reduce_tb.sv]
// self-checking testbench for the fraction add multiply reduce block
`timescale 1ns / 1ps

module fraction_add_multiply_reduce_tb;
   import fram_pkg::*;

   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam int         ITEMS_PHASE  = 442;
   localparam int         STALL_LIMIT  = 4000;
   localparam int         TAIL_CYCLES  = 200;

   typedef struct {
      req_type item;
      bit      known;
      rsp_type want;
   } vector_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   vector_row_type vectors[$];
   rsp_type        pending_fractions[$];
   int             error_count = 0;
   int             stall_cycles = 0;
   int unsigned    sender_idle = 0;

   fraction_add_multiply_reduce i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type predict_fraction(input req_type r);
      longint  na;
      longint  nb;
      longint  da;
      longint  db;
      longint  num;
      longint  den;
      longint  mag;
      longint  x;
      longint  y;
      longint  t;
      logic    neg;
      rsp_type o;
      na = longint'($signed(r.num_a));
      nb = longint'($signed(r.num_b));
      da = longint'(r.den_a);
      db = longint'(r.den_b);
      case (r.opcode)
         OP_MUL: begin
            num = na * nb;
            den = da * db;
         end
         OP_ADD: begin
            num = na * db + nb * da;
            den = da * db;
         end
         default: begin
            num = na;
            den = da;
         end
      endcase
      if (den == 0) begin
         o.res_num = '0;
         o.res_den = '0;
      end else begin
         neg = (num < 0);
         mag = neg ? -num : num;
         x = mag;
         y = den;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         mag = mag / x;
         o.res_num = NUM_W'(neg ? -mag : mag);
         o.res_den = DEN_W'(den / x);
      end
      return o;
   endfunction

   function automatic req_type random_fraction_item();
      req_type     r;
      int unsigned shape;
      r.opcode = 2'($urandom_range(3, 0));
      shape = $urandom_range(99);
      if (shape < 35) begin
         // small parts so that common factors are frequent
         r.num_a = PART_WIDTH'(int'($urandom_range(120)) - 60);
         r.num_b = PART_WIDTH'(int'($urandom_range(120)) - 60);
         r.den_a = DEN_IN_W'($urandom_range(60, 1));
         r.den_b = DEN_IN_W'($urandom_range(60, 1));
      end else begin
         r.num_a = PART_WIDTH'($urandom);
         r.num_b = PART_WIDTH'($urandom);
         r.den_a = DEN_IN_W'($urandom_range(32767, 1));
         r.den_b = DEN_IN_W'($urandom_range(32767, 1));
      end
      if ($urandom_range(99) < 4)
         r.den_a = '0;
      if ($urandom_range(99) < 4)
         r.den_b = '0;
      return r;
   endfunction

   task automatic add_vector(input logic [1:0] op, input int na, input int da, input int nb,
                             input int db, input bit known, input int wn, input int wd);
      vector_row_type row;
      row.item.opcode = op;
      row.item.num_a  = PART_WIDTH'(na);
      row.item.den_a  = DEN_IN_W'(da);
      row.item.num_b  = PART_WIDTH'(nb);
      row.item.den_b  = DEN_IN_W'(db);
      row.known       = known;
      row.want.res_num = NUM_W'(wn);
      row.want.res_den = DEN_W'(wd);
      vectors.push_back(row);
   endtask

   task automatic send_item(input req_type r, input bit known, input rsp_type want);
      int gap;
      gap = 0;
      if (sender_idle != 0 && $urandom_range(99) < 5)
         gap = $urandom_range(140, 1);
      else
         while (gap < 20 && $urandom_range(99) < sender_idle)
            gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_fractions.push_back(known ? want : predict_fraction(r));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_fractions.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0d/%0d", $time,
                     rsp_data.res_num, rsp_data.res_den);
            error_count++;
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_data.res_num !== want.res_num) begin
               $display("%0t res_num mismatch: expected %0d actual %0d", $time,
                        want.res_num, rsp_data.res_num);
               error_count++;
            end
            if (rsp_data.res_den !== want.res_den) begin
               $display("%0t res_den mismatch: expected %0d actual %0d", $time,
                        want.res_den, rsp_data.res_den);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, stall_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none     = '0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      add_vector(OP_REDUCE, 0, 5, 3, 7, 1, 0, 1);
      add_vector(OP_REDUCE, 7, 0, 1, 1, 1, 0, 0);
      add_vector(OP_REDUCE, 0, 0, 0, 0, 1, 0, 0);
      add_vector(OP_MUL, 3, 0, 2, 5, 1, 0, 0);
      add_vector(OP_MUL, 1, 3, 1, 0, 1, 0, 0);
      add_vector(OP_ADD, 1, 2, 1, 0, 1, 0, 0);
      add_vector(OP_REDUCE, 6, 4, -5, 9, 1, 3, 2);
      add_vector(OP_REDUCE, -12, 18, 32767, 1, 1, -2, 3);
      add_vector(OP_REDUCE, -32768, 1, 0, 0, 1, -32768, 1);
      add_vector(OP_REDUCE, 32767, 32767, -1, 2, 1, 1, 1);
      add_vector(OP_REDUCE, -32768, 32767, 0, 1, 0, 0, 0);
      add_vector(OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1);
      add_vector(OP_MUL, 32767, 32767, 32767, 32767, 1, 1, 1);
      add_vector(OP_MUL, -32768, 32767, 32767, 32767, 0, 0, 0);
      add_vector(OP_MUL, 0, 7, 5, 3, 1, 0, 1);
      add_vector(OP_MUL, 1, 32767, 1, 32767, 0, 0, 0);
      add_vector(OP_ADD, -32768, 1, -32768, 1, 1, -65536, 1);
      add_vector(OP_ADD, 32767, 1, 32767, 1, 1, 65534, 1);
      add_vector(OP_ADD, -32768, 32767, -32768, 32767, 0, 0, 0);
      add_vector(OP_ADD, 1, 2, -1, 2, 1, 0, 1);
      add_vector(OP_ADD, 1, 32767, 1, 32766, 0, 0, 0);
      add_vector(OP_ADD, -1, 3, 1, 6, 0, 0, 0);
      add_vector(OP_SPARE, 6, 4, 5, 7, 1, 3, 2);
      add_vector(OP_SPARE, 9, 0, 5, 7, 1, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i])
         send_item(vectors[i].item, vectors[i].known, vectors[i].want);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle = (phase == 0) ? 37 : (phase == 1) ? 45 : 0;
         repeat (ITEMS_PHASE)
            send_item(random_fraction_item(), 1'b0, none);
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_fractions.size() != 0) begin
         $display("%0t %0d results still outstanding", $time, pending_fractions.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/fram_pkg.sv
sv/fram_alu.sv
sv/fram_mul.sv
sv/fraction_add_multiply_reduce.sv
tb/fraction_add_multiply_reduce_tb.sv
